/* design/fcbu_pkg.sv */
package fcbu_pkg;

  // Default build parameters
  localparam int TRIG_STEPS_DEF    = 16;
  localparam int POS_FRAC_BITS_DEF = 16;

  // Fixed-point constants
  localparam int DEG_ONE      = 65536;
  localparam int QUARTER_TURN = 90 * DEG_ONE;
  localparam int AXIS_ONE     = 16384;
  localparam int CORDIC_START = 1 << 20;
  localparam int WRAP_UNIT    = 360;
  localparam int WRAP_BIAS    = 360 * 184;
  localparam int WRAP_STEPS   = 9;
  localparam int SQRT_STEPS   = 23;
  localparam int SQRT_TOP     = 44;
  localparam int DIV_STEPS    = 15;
  localparam int YAW_RESET    = 270 * DEG_ONE;

  // Operation codes
  localparam logic [1:0] OP_PLACE  = 2'd0;
  localparam logic [1:0] OP_MOVE   = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;

  // Move directions
  localparam logic [2:0] DIR_FWD   = 3'd0;
  localparam logic [2:0] DIR_BACK  = 3'd1;
  localparam logic [2:0] DIR_RIGHT = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_UP    = 3'd4;
  localparam logic [2:0] DIR_DOWN  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP    = 2'd0;
  localparam logic [1:0] CFG_START_X = 2'd1;
  localparam logic [1:0] CFG_START_Y = 2'd2;
  localparam logic [1:0] CFG_START_Z = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [2:0]         direction;
    logic signed [15:0] pointer_x;
    logic signed [15:0] pointer_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [15:0] rgt_x;
    logic signed [15:0] rgt_y;
    logic signed [15:0] rgt_z;
    logic signed [15:0] upv_x;
    logic signed [15:0] upv_y;
    logic signed [15:0] upv_z;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_PLACE, ST_MV_MUL, ST_MV_ACC, ST_ROT_PREP, ST_ROT_WRAP,
    ST_ROT_DONE, ST_TRIG_INIT, ST_TRIG_ITER, ST_TRIG_DONE, ST_SQ, ST_SUM, ST_SQRT,
    ST_DIV_INIT, ST_DIV_ITER, ST_DIV_DONE, ST_RGT_LOAD, ST_UP_MUL, ST_UP_RND, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_ACCEPT, DP_PLACE, DP_MV_MUL, DP_MV_ACC, DP_ROT_PREP, DP_ROT_WRAP,
    DP_ROT_DONE, DP_TRIG_INIT, DP_TRIG_ITER, DP_TRIG_DONE, DP_SQ, DP_SUM, DP_SQRT,
    DP_DIV_INIT, DP_DIV_ITER, DP_DIV_DONE, DP_RGT_LOAD, DP_UP_MUL, DP_UP_RND, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
    logic [4:0] k;
    logic       rgt;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] dir;
    logic       out_free;
  } status_t;

  // Arctangent of 2^-i in Q16.16 degrees
  function automatic logic [22:0] atan_deg(input logic [4:0] i);
    logic [22:0] v;
    unique case (i)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      5'd18:   v = 23'd14;
      5'd19:   v = 23'd7;
      5'd20:   v = 23'd4;
      5'd21:   v = 23'd2;
      5'd22:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/fcbu_ctrl.sv */
module fcbu_ctrl #(
  parameter int TRIG_STEPS = fcbu_pkg::TRIG_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fcbu_pkg::status_t status,
  output fcbu_pkg::cmd_t    cmd
);

  fcbu_pkg::state_t state_r, state_nxt;
  logic [4:0] k_r, k_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       rgt_r, rgt_nxt;

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcbu_pkg::ST_IDLE;
      k_r     <= '0;
      idx_r   <= '0;
      rgt_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      idx_r   <= idx_nxt;
      rgt_r   <= rgt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    rgt_nxt   = rgt_r;
    unique case (state_r)
      fcbu_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = fcbu_pkg::ST_DISPATCH;
      end
      fcbu_pkg::ST_DISPATCH: begin
        idx_nxt = '0;
        rgt_nxt = 1'b0;
        k_nxt   = '0;
        priority if (status.op == fcbu_pkg::OP_PLACE) begin
          state_nxt = fcbu_pkg::ST_PLACE;
        end else if (status.op == fcbu_pkg::OP_MOVE && status.dir <= fcbu_pkg::DIR_DOWN) begin
          state_nxt = fcbu_pkg::ST_MV_MUL;
        end else if (status.op == fcbu_pkg::OP_ROTATE) begin
          state_nxt = fcbu_pkg::ST_ROT_PREP;
        end else begin
          state_nxt = fcbu_pkg::ST_TRIG_INIT;
        end
      end
      fcbu_pkg::ST_PLACE:  state_nxt = fcbu_pkg::ST_TRIG_INIT;
      fcbu_pkg::ST_MV_MUL: state_nxt = fcbu_pkg::ST_MV_ACC;
      fcbu_pkg::ST_MV_ACC: begin
        if (idx_r == 2'd2) begin
          state_nxt = fcbu_pkg::ST_TRIG_INIT;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = fcbu_pkg::ST_MV_MUL;
        end
      end
      fcbu_pkg::ST_ROT_PREP: begin
        k_nxt     = 5'(fcbu_pkg::WRAP_STEPS - 1);
        state_nxt = fcbu_pkg::ST_ROT_WRAP;
      end
      fcbu_pkg::ST_ROT_WRAP: begin
        if (k_r == '0) state_nxt = fcbu_pkg::ST_ROT_DONE;
        else k_nxt = k_r - 5'd1;
      end
      fcbu_pkg::ST_ROT_DONE: state_nxt = fcbu_pkg::ST_TRIG_INIT;
      fcbu_pkg::ST_TRIG_INIT: begin
        k_nxt     = '0;
        state_nxt = fcbu_pkg::ST_TRIG_ITER;
      end
      fcbu_pkg::ST_TRIG_ITER: begin
        if (k_r == 5'(TRIG_STEPS - 1)) state_nxt = fcbu_pkg::ST_TRIG_DONE;
        else k_nxt = k_r + 5'd1;
      end
      fcbu_pkg::ST_TRIG_DONE: state_nxt = fcbu_pkg::ST_SQ;
      fcbu_pkg::ST_SQ:        state_nxt = fcbu_pkg::ST_SUM;
      fcbu_pkg::ST_SUM: begin
        k_nxt     = '0;
        state_nxt = fcbu_pkg::ST_SQRT;
      end
      fcbu_pkg::ST_SQRT: begin
        if (k_r == 5'(fcbu_pkg::SQRT_STEPS - 1)) state_nxt = fcbu_pkg::ST_DIV_INIT;
        else k_nxt = k_r + 5'd1;
      end
      fcbu_pkg::ST_DIV_INIT: begin
        k_nxt     = 5'(fcbu_pkg::DIV_STEPS - 1);
        state_nxt = fcbu_pkg::ST_DIV_ITER;
      end
      fcbu_pkg::ST_DIV_ITER: begin
        if (k_r == '0) state_nxt = fcbu_pkg::ST_DIV_DONE;
        else k_nxt = k_r - 5'd1;
      end
      fcbu_pkg::ST_DIV_DONE: begin
        idx_nxt   = '0;
        state_nxt = rgt_r ? fcbu_pkg::ST_UP_MUL : fcbu_pkg::ST_RGT_LOAD;
      end
      fcbu_pkg::ST_RGT_LOAD: begin
        rgt_nxt   = 1'b1;
        state_nxt = fcbu_pkg::ST_SQ;
      end
      fcbu_pkg::ST_UP_MUL: state_nxt = fcbu_pkg::ST_UP_RND;
      fcbu_pkg::ST_UP_RND: begin
        if (idx_r == 2'd2) begin
          state_nxt = fcbu_pkg::ST_OUT;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = fcbu_pkg::ST_UP_MUL;
        end
      end
      fcbu_pkg::ST_OUT: begin
        if (status.out_free) state_nxt = fcbu_pkg::ST_IDLE;
      end
      default: state_nxt = fcbu_pkg::ST_IDLE;
    endcase
  end

  // Outputs: datapath command and input stall
  always_comb begin
    cmd.idx  = idx_r;
    cmd.k    = k_r;
    cmd.rgt  = rgt_r;
    in_stall = (state_r != fcbu_pkg::ST_IDLE);
    unique case (state_r)
      fcbu_pkg::ST_IDLE:      cmd.op = in_valid ? fcbu_pkg::DP_ACCEPT : fcbu_pkg::DP_NOP;
      fcbu_pkg::ST_PLACE:     cmd.op = fcbu_pkg::DP_PLACE;
      fcbu_pkg::ST_MV_MUL:    cmd.op = fcbu_pkg::DP_MV_MUL;
      fcbu_pkg::ST_MV_ACC:    cmd.op = fcbu_pkg::DP_MV_ACC;
      fcbu_pkg::ST_ROT_PREP:  cmd.op = fcbu_pkg::DP_ROT_PREP;
      fcbu_pkg::ST_ROT_WRAP:  cmd.op = fcbu_pkg::DP_ROT_WRAP;
      fcbu_pkg::ST_ROT_DONE:  cmd.op = fcbu_pkg::DP_ROT_DONE;
      fcbu_pkg::ST_TRIG_INIT: cmd.op = fcbu_pkg::DP_TRIG_INIT;
      fcbu_pkg::ST_TRIG_ITER: cmd.op = fcbu_pkg::DP_TRIG_ITER;
      fcbu_pkg::ST_TRIG_DONE: cmd.op = fcbu_pkg::DP_TRIG_DONE;
      fcbu_pkg::ST_SQ:        cmd.op = fcbu_pkg::DP_SQ;
      fcbu_pkg::ST_SUM:       cmd.op = fcbu_pkg::DP_SUM;
      fcbu_pkg::ST_SQRT:      cmd.op = fcbu_pkg::DP_SQRT;
      fcbu_pkg::ST_DIV_INIT:  cmd.op = fcbu_pkg::DP_DIV_INIT;
      fcbu_pkg::ST_DIV_ITER:  cmd.op = fcbu_pkg::DP_DIV_ITER;
      fcbu_pkg::ST_DIV_DONE:  cmd.op = fcbu_pkg::DP_DIV_DONE;
      fcbu_pkg::ST_RGT_LOAD:  cmd.op = fcbu_pkg::DP_RGT_LOAD;
      fcbu_pkg::ST_UP_MUL:    cmd.op = fcbu_pkg::DP_UP_MUL;
      fcbu_pkg::ST_UP_RND:    cmd.op = fcbu_pkg::DP_UP_RND;
      fcbu_pkg::ST_OUT:       cmd.op = status.out_free ? fcbu_pkg::DP_OUT : fcbu_pkg::DP_NOP;
      default:                cmd.op = fcbu_pkg::DP_NOP;
    endcase
  end

endmodule

/* design/fcbu_datapath.sv */
module fcbu_datapath #(
  parameter int POS_FRAC_BITS = fcbu_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fcbu_pkg::cmd_t      cmd,
  output fcbu_pkg::status_t   status,
  input  fcbu_pkg::in_word_t  in_data,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                out_stall,
  output logic                out_valid,
  output fcbu_pkg::out_word_t out_data
);

  localparam int MV_SHIFT = 30 - POS_FRAC_BITS;

  // Configuration and item registers
  logic [23:0]        step_r;
  logic signed [31:0] start_r [3];
  fcbu_pkg::in_word_t item_r;

  // Camera state
  logic signed [31:0] pos_r [3];
  logic [24:0]        yaw_r, pitch_r;
  logic signed [15:0] fwd_r [3];
  logic signed [15:0] rgt_r [3];
  logic signed [15:0] upv_r [3];
  logic signed [15:0] lastp_r [2];
  logic               seen_r;

  // Work registers
  logic signed [40:0] prod_r;
  logic [17:0]        wrap_r [2];
  logic signed [23:0] cx_r [2];
  logic signed [23:0] cy_r [2];
  logic signed [23:0] cz_r [2];
  logic [1:0]         quad_r [2];
  logic signed [24:0] v_r [3];
  logic [47:0]        sq_r [3];
  logic [47:0]        rad_r, root_r, bit_r;
  logic [23:0]        len_r;
  logic [38:0]        rem_r [3];
  logic [14:0]        quo_r [3];
  logic               neg_r [3];
  logic signed [32:0] up_p_r;
  logic               out_valid_r;
  fcbu_pkg::out_word_t out_r;

  // Move offset and saturating add
  logic signed [15:0] mv_comp;
  logic               mv_add;
  logic [40:0]        mv_mag, mv_off;
  logic signed [42:0] mv_offs, mv_sum;
  logic signed [31:0] mv_pos;

  always_comb begin
    priority if (item_r.direction == fcbu_pkg::DIR_FWD ||
                 item_r.direction == fcbu_pkg::DIR_BACK) begin
      mv_comp = fwd_r[cmd.idx];
    end else if (item_r.direction == fcbu_pkg::DIR_RIGHT ||
                 item_r.direction == fcbu_pkg::DIR_LEFT) begin
      mv_comp = rgt_r[cmd.idx];
    end else begin
      mv_comp = upv_r[cmd.idx];
    end
    mv_add  = (item_r.direction == fcbu_pkg::DIR_FWD) ||
              (item_r.direction == fcbu_pkg::DIR_LEFT) ||
              (item_r.direction == fcbu_pkg::DIR_DOWN);
    mv_mag  = prod_r[40] ? 41'(-prod_r) : 41'(prod_r);
    mv_off  = (mv_mag + (41'd1 << (MV_SHIFT - 1))) >> MV_SHIFT;
    mv_offs = prod_r[40] ? -$signed({2'b00, mv_off}) : $signed({2'b00, mv_off});
    mv_sum  = mv_add ? 43'(pos_r[cmd.idx]) + mv_offs : 43'(pos_r[cmd.idx]) - mv_offs;
    priority if (mv_sum > 43'sd2147483647) mv_pos = 32'sh7fffffff;
    else if (mv_sum < -43'sd2147483648) mv_pos = 32'sh80000000;
    else mv_pos = mv_sum[31:0];
  end

  // Pointer deltas biased to stay positive before the modulo 360 pass
  logic signed [15:0] last_x, last_y;
  logic signed [18:0] wy_s, wp_s;
  logic [17:0]        wrap_lim;

  always_comb begin
    last_x   = seen_r ? lastp_r[0] : item_r.pointer_x;
    last_y   = seen_r ? lastp_r[1] : item_r.pointer_y;
    wy_s     = $signed({10'b0, yaw_r[24:16]}) + 19'(item_r.pointer_x) - 19'(last_x) +
               19'(fcbu_pkg::WRAP_BIAS);
    wp_s     = $signed({10'b0, pitch_r[24:16]}) + 19'(item_r.pointer_y) - 19'(last_y) +
               19'(fcbu_pkg::WRAP_BIAS);
    wrap_lim = 18'(fcbu_pkg::WRAP_UNIT) << cmd.k[3:0];
  end

  // Quadrant reduction and CORDIC step for both angles
  logic [24:0]        ang [2];
  logic [1:0]         q_init [2];
  logic [24:0]        r_init [2];
  logic signed [23:0] sh_x [2];
  logic signed [23:0] sh_y [2];
  logic signed [23:0] atan_k;
  logic signed [24:0] cos_o [2];
  logic signed [24:0] sin_o [2];

  always_comb begin
    ang[0] = yaw_r;
    ang[1] = pitch_r;
    atan_k = $signed({1'b0, fcbu_pkg::atan_deg(cmd.k)});
    for (int l = 0; l < 2; l++) begin
      priority if (ang[l] >= 25'(3 * fcbu_pkg::QUARTER_TURN)) begin
        q_init[l] = 2'd3;
        r_init[l] = ang[l] - 25'(3 * fcbu_pkg::QUARTER_TURN);
      end else if (ang[l] >= 25'(2 * fcbu_pkg::QUARTER_TURN)) begin
        q_init[l] = 2'd2;
        r_init[l] = ang[l] - 25'(2 * fcbu_pkg::QUARTER_TURN);
      end else if (ang[l] >= 25'(fcbu_pkg::QUARTER_TURN)) begin
        q_init[l] = 2'd1;
        r_init[l] = ang[l] - 25'(fcbu_pkg::QUARTER_TURN);
      end else begin
        q_init[l] = 2'd0;
        r_init[l] = ang[l];
      end
      sh_x[l] = cx_r[l] >>> cmd.k;
      sh_y[l] = cy_r[l] >>> cmd.k;
      unique case (quad_r[l])
        2'd0: begin cos_o[l] = 25'(cx_r[l]);  sin_o[l] = 25'(cy_r[l]);  end
        2'd1: begin cos_o[l] = -25'(cy_r[l]); sin_o[l] = 25'(cx_r[l]);  end
        2'd2: begin cos_o[l] = -25'(cx_r[l]); sin_o[l] = -25'(cy_r[l]); end
        default: begin cos_o[l] = 25'(cy_r[l]); sin_o[l] = -25'(cx_r[l]); end
      endcase
    end
  end

  // Square root step, divider step and normalized component
  logic [47:0]        sq_trial;
  logic [38:0]        div_den;
  logic [24:0]        v_mag [3];
  logic signed [15:0] div_comp [3];

  always_comb begin
    sq_trial = root_r + bit_r;
    div_den  = 39'(len_r) << cmd.k[3:0];
    for (int i = 0; i < 3; i++) begin
      v_mag[i] = v_r[i][24] ? 25'(-v_r[i]) : 25'(v_r[i]);
      if (len_r == '0) div_comp[i] = '0;
      else if (neg_r[i]) div_comp[i] = -$signed({1'b0, quo_r[i]});
      else div_comp[i] = $signed({1'b0, quo_r[i]});
    end
  end

  // Up axis cross product term and its rounding
  logic signed [15:0] ua, ub, uc, ud;
  logic [32:0]        up_mag;
  logic [18:0]        up_q;
  logic [14:0]        up_c;
  logic signed [15:0] up_comp;

  always_comb begin
    unique case (cmd.idx)
      2'd0:    begin ua = fwd_r[1]; ub = rgt_r[2]; uc = fwd_r[2]; ud = rgt_r[1]; end
      2'd1:    begin ua = fwd_r[2]; ub = rgt_r[0]; uc = fwd_r[0]; ud = rgt_r[2]; end
      default: begin ua = fwd_r[0]; ub = rgt_r[1]; uc = fwd_r[1]; ud = rgt_r[0]; end
    endcase
    up_mag  = up_p_r[32] ? 33'(-up_p_r) : 33'(up_p_r);
    up_q    = 19'((up_mag + 33'd8192) >> 14);
    up_c    = (up_q > 19'(fcbu_pkg::AXIS_ONE)) ? 15'(fcbu_pkg::AXIS_ONE) : up_q[14:0];
    up_comp = up_p_r[32] ? -$signed({1'b0, up_c}) : $signed({1'b0, up_c});
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= 24'd65536;
      start_r[0] <= '0;
      start_r[1] <= '0;
      start_r[2] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fcbu_pkg::CFG_STEP:    step_r     <= cfg_data[23:0];
        fcbu_pkg::CFG_START_X: start_r[0] <= cfg_data;
        fcbu_pkg::CFG_START_Y: start_r[1] <= cfg_data;
        fcbu_pkg::CFG_START_Z: start_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Camera state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r[0]   <= '0;
      pos_r[1]   <= '0;
      pos_r[2]   <= '0;
      yaw_r      <= 25'(fcbu_pkg::YAW_RESET);
      pitch_r    <= '0;
      fwd_r[0]   <= '0;
      fwd_r[1]   <= '0;
      fwd_r[2]   <= -16'(fcbu_pkg::AXIS_ONE);
      rgt_r[0]   <= -16'(fcbu_pkg::AXIS_ONE);
      rgt_r[1]   <= '0;
      rgt_r[2]   <= '0;
      upv_r[0]   <= '0;
      upv_r[1]   <= 16'(fcbu_pkg::AXIS_ONE);
      upv_r[2]   <= '0;
      lastp_r[0] <= '0;
      lastp_r[1] <= '0;
      seen_r     <= 1'b0;
    end else begin
      unique case (cmd.op)
        fcbu_pkg::DP_PLACE: begin
          for (int i = 0; i < 3; i++) pos_r[i] <= start_r[i];
          yaw_r   <= 25'(fcbu_pkg::YAW_RESET);
          pitch_r <= '0;
        end
        fcbu_pkg::DP_MV_ACC: pos_r[cmd.idx] <= mv_pos;
        fcbu_pkg::DP_ROT_PREP: begin
          lastp_r[0] <= item_r.pointer_x;
          lastp_r[1] <= item_r.pointer_y;
          seen_r     <= 1'b1;
        end
        fcbu_pkg::DP_ROT_DONE: begin
          yaw_r   <= {wrap_r[0][8:0], yaw_r[15:0]};
          pitch_r <= {wrap_r[1][8:0], pitch_r[15:0]};
        end
        fcbu_pkg::DP_DIV_DONE: begin
          for (int i = 0; i < 3; i++) begin
            if (cmd.rgt) rgt_r[i] <= div_comp[i];
            else fwd_r[i] <= div_comp[i];
          end
        end
        fcbu_pkg::DP_UP_RND: upv_r[cmd.idx] <= up_comp;
        default: ;
      endcase
    end
  end

  // Working datapath registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      fcbu_pkg::DP_ACCEPT: item_r <= in_data;
      fcbu_pkg::DP_MV_MUL: prod_r <= mv_comp * $signed({1'b0, step_r});
      fcbu_pkg::DP_ROT_PREP: begin
        wrap_r[0] <= wy_s[17:0];
        wrap_r[1] <= wp_s[17:0];
      end
      fcbu_pkg::DP_ROT_WRAP: begin
        for (int l = 0; l < 2; l++) begin
          if (wrap_r[l] >= wrap_lim) wrap_r[l] <= wrap_r[l] - wrap_lim;
        end
      end
      fcbu_pkg::DP_TRIG_INIT: begin
        for (int l = 0; l < 2; l++) begin
          cx_r[l]   <= 24'(fcbu_pkg::CORDIC_START);
          cy_r[l]   <= '0;
          cz_r[l]   <= $signed(r_init[l][23:0]);
          quad_r[l] <= q_init[l];
        end
      end
      fcbu_pkg::DP_TRIG_ITER: begin
        for (int l = 0; l < 2; l++) begin
          if (!cz_r[l][23]) begin
            cx_r[l] <= cx_r[l] - sh_y[l];
            cy_r[l] <= cy_r[l] + sh_x[l];
            cz_r[l] <= cz_r[l] - atan_k;
          end else begin
            cx_r[l] <= cx_r[l] + sh_y[l];
            cy_r[l] <= cy_r[l] - sh_x[l];
            cz_r[l] <= cz_r[l] + atan_k;
          end
        end
      end
      fcbu_pkg::DP_TRIG_DONE: begin
        v_r[0] <= cos_o[0];
        v_r[1] <= sin_o[1];
        v_r[2] <= sin_o[0];
      end
      fcbu_pkg::DP_RGT_LOAD: begin
        v_r[0] <= 25'(fwd_r[2]);
        v_r[1] <= '0;
        v_r[2] <= -25'(fwd_r[0]);
      end
      fcbu_pkg::DP_SQ: begin
        for (int i = 0; i < 3; i++) sq_r[i] <= 48'(v_r[i]) * 48'(v_r[i]);
      end
      fcbu_pkg::DP_SUM: begin
        rad_r  <= sq_r[0] + sq_r[1] + sq_r[2];
        root_r <= '0;
        bit_r  <= 48'd1 << fcbu_pkg::SQRT_TOP;
      end
      fcbu_pkg::DP_SQRT: begin
        if (rad_r >= sq_trial) begin
          rad_r  <= rad_r - sq_trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      fcbu_pkg::DP_DIV_INIT: begin
        len_r <= root_r[23:0];
        for (int i = 0; i < 3; i++) begin
          rem_r[i] <= (39'(v_mag[i]) << 14) + 39'(root_r[23:1]);
          quo_r[i] <= '0;
          neg_r[i] <= v_r[i][24];
        end
      end
      fcbu_pkg::DP_DIV_ITER: begin
        for (int i = 0; i < 3; i++) begin
          if (rem_r[i] >= div_den) begin
            rem_r[i]            <= rem_r[i] - div_den;
            quo_r[i][cmd.k[3:0]] <= 1'b1;
          end
        end
      end
      fcbu_pkg::DP_UP_MUL: up_p_r <= 33'(ua) * 33'(ub) - 33'(uc) * 33'(ud);
      fcbu_pkg::DP_OUT: begin
        out_r.pos_x <= pos_r[0];
        out_r.pos_y <= pos_r[1];
        out_r.pos_z <= pos_r[2];
        out_r.fwd_x <= fwd_r[0];
        out_r.fwd_y <= fwd_r[1];
        out_r.fwd_z <= fwd_r[2];
        out_r.rgt_x <= rgt_r[0];
        out_r.rgt_y <= rgt_r[1];
        out_r.rgt_z <= rgt_r[2];
        out_r.upv_x <= upv_r[0];
        out_r.upv_y <= upv_r[1];
        out_r.upv_z <= upv_r[2];
      end
      default: ;
    endcase
  end

  // Output word valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == fcbu_pkg::DP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign status.op       = item_r.operation;
  assign status.dir      = item_r.direction;
  assign status.out_free = !out_valid_r || !out_stall;

endmodule

/* design/fly_camera_basis_update.sv */
// From accept to out_valid a word runs any place, move or rotate step, the CORDIC, two
// normalize passes (square root, then divide) and the up axis; the two passes dominate.
// Throughput: one word at a time; the next word is taken once the result is in the output
// register, which waits while the previous result there is still stalled.
// Reset (rst_n low, synchronous): position 0, yaw 270, pitch 0, default axes, step 1.0,
// start position 0, output empty.
module fly_camera_basis_update #(
  parameter int TRIG_STEPS    = fcbu_pkg::TRIG_STEPS_DEF,
  parameter int POS_FRAC_BITS = fcbu_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fcbu_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fcbu_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  fcbu_pkg::cmd_t    cmd;
  fcbu_pkg::status_t status;

  assign cfg_ready = 1'b1;

  fcbu_ctrl #(
    .TRIG_STEPS(TRIG_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fcbu_datapath #(
    .POS_FRAC_BITS(POS_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* design/fcbu_checker.sv */
module fcbu_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input fcbu_pkg::out_word_t out_data
);

  // A stalled result word stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // Once a word is taken the block is busy on it
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  // A stalled result word keeps its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result word changed while stalled");

endmodule

bind fly_camera_basis_update fcbu_checker u_fcbu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* bench/fly_camera_basis_update_test.sv */
`timescale 1ns / 100ps
module fly_camera_basis_update_test;

  localparam int FULL_TURN = 360 * fcbu_pkg::DEG_ONE;
  localparam int HOLD_LEN  = 2000;

  logic clk;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_stall;
  fcbu_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fcbu_pkg::out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  fly_camera_basis_update u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Camera state mirrored by the predictor
  logic [23:0] cam_step = 24'd65536;
  logic signed [31:0] cam_start [3] = '{0, 0, 0};
  logic signed [31:0] cam_pos [3] = '{0, 0, 0};
  logic [31:0] cam_yaw = 32'(fcbu_pkg::YAW_RESET);
  logic [31:0] cam_pitch = '0;
  logic signed [31:0] cam_fwd [3] = '{0, 0, -fcbu_pkg::AXIS_ONE};
  logic signed [31:0] cam_rgt [3] = '{-fcbu_pkg::AXIS_ONE, 0, 0};
  logic signed [31:0] cam_upv [3] = '{0, fcbu_pkg::AXIS_ONE, 0};
  logic signed [31:0] cam_last_ptr [2] = '{0, 0};
  logic cam_ptr_seen = 1'b0;

  fcbu_pkg::in_word_t pending_words[$];
  fcbu_pkg::out_word_t expected_views[$];
  int errors = 0;
  int send_idle_pct;
  int recv_idle_pct;
  bit recv_hold;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  // Arithmetic shift that floors toward minus infinity
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clip_axis(longint v);
    if (v > fcbu_pkg::AXIS_ONE) return fcbu_pkg::AXIS_ONE;
    if (v < -fcbu_pkg::AXIS_ONE) return -fcbu_pkg::AXIS_ONE;
    return v;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint atan_entry(int i);
    longint tab [24];
    tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    return tab[i];
  endfunction

  task automatic cordic_sincos(input logic [31:0] a, output longint c, output longint s);
    int quad;
    longint z, x, y, t;
    quad = int'((a / fcbu_pkg::QUARTER_TURN) % 4);
    z = longint'(a % fcbu_pkg::QUARTER_TURN);
    x = fcbu_pkg::CORDIC_START;
    y = 0;
    for (int i = 0; i < fcbu_pkg::TRIG_STEPS_DEF && i < 24; i++) begin
      if (z >= 0) begin
        t = x - shr_floor(y, i); y = y + shr_floor(x, i); z = z - atan_entry(i);
      end else begin
        t = x + shr_floor(y, i); y = y - shr_floor(x, i); z = z + atan_entry(i);
      end
      x = t;
    end
    case (quad)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic unit_vector(input longint v [3], output logic signed [31:0] r [3]);
    longint ss, len;
    ss = 0;
    for (int i = 0; i < 3; i++) ss += v[i] * v[i];
    len = int_sqrt(ss);
    for (int i = 0; i < 3; i++)
      r[i] = (len == 0) ? 32'sd0
             : 32'(clip_axis(round_div(v[i] * fcbu_pkg::AXIS_ONE, len)));
  endtask

  task automatic rebuild_basis();
    longint cy, sy, cp, sp;
    longint v [3];
    longint f [3];
    longint g [3];
    cordic_sincos(cam_yaw, cy, sy);
    cordic_sincos(cam_pitch, cp, sp);
    v = '{cy, sp, sy};
    unit_vector(v, cam_fwd);
    v = '{cam_fwd[2], 0, -longint'(cam_fwd[0])};
    unit_vector(v, cam_rgt);
    for (int i = 0; i < 3; i++) begin
      f[i] = cam_fwd[i];
      g[i] = cam_rgt[i];
    end
    cam_upv[0] = 32'(clip_axis(round_div(f[1] * g[2] - f[2] * g[1], fcbu_pkg::AXIS_ONE)));
    cam_upv[1] = 32'(clip_axis(round_div(f[2] * g[0] - f[0] * g[2], fcbu_pkg::AXIS_ONE)));
    cam_upv[2] = 32'(clip_axis(round_div(f[0] * g[1] - f[1] * g[0], fcbu_pkg::AXIS_ONE)));
  endtask

  task automatic step_along(input logic signed [31:0] ax [3], input bit add);
    longint off, p;
    for (int i = 0; i < 3; i++) begin
      off = round_div(longint'(ax[i]) * longint'(cam_step),
                      64'sd1 << (30 - fcbu_pkg::POS_FRAC_BITS_DEF));
      p = add ? longint'(cam_pos[i]) + off : longint'(cam_pos[i]) - off;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      cam_pos[i] = 32'(p);
    end
  endtask

  function automatic logic [31:0] turn_angle(logic [31:0] a, longint d);
    longint t;
    t = (longint'(a) + d * fcbu_pkg::DEG_ONE) % FULL_TURN;
    if (t < 0) t += FULL_TURN;
    return 32'(t);
  endfunction

  // Compute the camera view after one word
  task automatic predict_view(input fcbu_pkg::in_word_t w);
    fcbu_pkg::out_word_t e;
    if (w.operation == fcbu_pkg::OP_PLACE) begin
      for (int i = 0; i < 3; i++) cam_pos[i] = cam_start[i];
      cam_yaw = 32'(fcbu_pkg::YAW_RESET);
      cam_pitch = '0;
    end else if (w.operation == fcbu_pkg::OP_MOVE) begin
      case (w.direction)
        fcbu_pkg::DIR_FWD:   step_along(cam_fwd, 1'b1);
        fcbu_pkg::DIR_BACK:  step_along(cam_fwd, 1'b0);
        fcbu_pkg::DIR_RIGHT: step_along(cam_rgt, 1'b0);
        fcbu_pkg::DIR_LEFT:  step_along(cam_rgt, 1'b1);
        fcbu_pkg::DIR_UP:    step_along(cam_upv, 1'b0);
        fcbu_pkg::DIR_DOWN:  step_along(cam_upv, 1'b1);
        default: ;
      endcase
    end else if (w.operation == fcbu_pkg::OP_ROTATE) begin
      if (!cam_ptr_seen) begin
        cam_last_ptr[0] = 32'(w.pointer_x);
        cam_last_ptr[1] = 32'(w.pointer_y);
        cam_ptr_seen = 1'b1;
      end
      cam_yaw = turn_angle(cam_yaw, longint'(w.pointer_x) - cam_last_ptr[0]);
      cam_pitch = turn_angle(cam_pitch, longint'(w.pointer_y) - cam_last_ptr[1]);
      cam_last_ptr[0] = 32'(w.pointer_x);
      cam_last_ptr[1] = 32'(w.pointer_y);
    end
    rebuild_basis();
    e.pos_x = cam_pos[0]; e.pos_y = cam_pos[1]; e.pos_z = cam_pos[2];
    e.fwd_x = 16'(cam_fwd[0]); e.fwd_y = 16'(cam_fwd[1]); e.fwd_z = 16'(cam_fwd[2]);
    e.rgt_x = 16'(cam_rgt[0]); e.rgt_y = 16'(cam_rgt[1]); e.rgt_z = 16'(cam_rgt[2]);
    e.upv_x = 16'(cam_upv[0]); e.upv_y = 16'(cam_upv[1]); e.upv_z = 16'(cam_upv[2]);
    expected_views.push_back(e);
  endtask

  // Driver: offer queued words, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_view(in_data);
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
    end else if (recv_hold && hold_cycles < HOLD_LEN) begin
      hold_cycles <= hold_cycles + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: compare each accepted view with the oldest expectation
  always @(posedge clk) begin
    fcbu_pkg::out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_views.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        errors++;
      end else begin
        e = expected_views.pop_front();
        if (e.pos_x !== out_data.pos_x || e.pos_y !== out_data.pos_y ||
            e.pos_z !== out_data.pos_z || e.fwd_x !== out_data.fwd_x ||
            e.fwd_y !== out_data.fwd_y || e.fwd_z !== out_data.fwd_z ||
            e.rgt_x !== out_data.rgt_x || e.rgt_y !== out_data.rgt_y ||
            e.rgt_z !== out_data.rgt_z || e.upv_x !== out_data.upv_x ||
            e.upv_y !== out_data.upv_y || e.upv_z !== out_data.upv_z) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fcbu_pkg::CFG_STEP) cam_step = val[23:0];
    else cam_start[idx - 1] = val;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_views.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic fcbu_pkg::in_word_t make_word(logic [1:0] op, logic [2:0] dir,
                                                   logic [15:0] px, logic [15:0] py);
    fcbu_pkg::in_word_t w;
    w.operation = op; w.direction = dir; w.pointer_x = px; w.pointer_y = py;
    return w;
  endfunction

  function automatic fcbu_pkg::in_word_t random_word();
    logic [1:0] op;
    int r;
    r = $urandom_range(99);
    if (r < 5) op = 2'd3;
    else if (r < 12) op = fcbu_pkg::OP_PLACE;
    else if (r < 60) op = fcbu_pkg::OP_MOVE;
    else op = fcbu_pkg::OP_ROTATE;
    return make_word(op, ($urandom_range(99) < 8) ? 3'($urandom_range(7, 6))
                         : 3'($urandom_range(5)),
                     ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400)),
                     ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400)));
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) pending_words.push_back(random_word());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = fcbu_pkg::CFG_STEP;
    cfg_data = '0;
    send_idle_pct = 34;
    recv_idle_pct = 88;
    recv_hold = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: moves before any rotate, first rotate only records the pointer
    for (int d = 0; d < 8; d++)
      pending_words.push_back(make_word(fcbu_pkg::OP_MOVE, 3'(d), 0, 0));
    pending_words.push_back(make_word(fcbu_pkg::OP_ROTATE, fcbu_pkg::DIR_FWD,
                                      16'h7fff, 16'h8000));
    pending_words.push_back(make_word(fcbu_pkg::OP_ROTATE, fcbu_pkg::DIR_FWD,
                                      16'h8000, 16'h7fff));
    pending_words.push_back(make_word(fcbu_pkg::OP_ROTATE, fcbu_pkg::DIR_FWD,
                                      16'h8045, 16'h7fd0));
    pending_words.push_back(make_word(fcbu_pkg::OP_ROTATE, fcbu_pkg::DIR_FWD,
                                      16'h8045, 16'h7faa));
    for (int d = 0; d < 6; d++)
      pending_words.push_back(make_word(fcbu_pkg::OP_MOVE, 3'(d), 0, 0));
    pending_words.push_back(make_word(2'd3, 3'd7, 16'hffff, 16'hffff));
    pending_words.push_back(make_word(fcbu_pkg::OP_PLACE, fcbu_pkg::DIR_FWD, 0, 0));
    drain();

    // Extreme settings: saturate position
    write_reg(fcbu_pkg::CFG_STEP, 32'hffffff);
    write_reg(fcbu_pkg::CFG_START_X, 32'h7fffff00);
    write_reg(fcbu_pkg::CFG_START_Y, 32'h80000000);
    write_reg(fcbu_pkg::CFG_START_Z, 32'h7fffffff);
    pending_words.push_back(make_word(fcbu_pkg::OP_PLACE, fcbu_pkg::DIR_FWD, 0, 0));
    for (int d = 0; d < 6; d++)
      pending_words.push_back(make_word(fcbu_pkg::OP_MOVE, 3'(d), 0, 0));
    run_random(200);
    drain();

    // Receiver holds off while the sender keeps offering
    send_idle_pct = 88;
    recv_idle_pct = 34;
    write_reg(fcbu_pkg::CFG_STEP, 32'h0);
    write_reg(fcbu_pkg::CFG_START_X, 32'h80000000);
    write_reg(fcbu_pkg::CFG_START_Z, 32'h0);
    run_random(200);
    recv_hold = 1'b1;
    drain();
    recv_hold = 1'b0;

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(fcbu_pkg::CFG_STEP, $urandom_range(24'hffffff));
    write_reg(fcbu_pkg::CFG_START_Y, $urandom);
    run_random(280);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
design/fcbu_pkg.sv
design/fcbu_ctrl.sv
design/fcbu_datapath.sv
design/fly_camera_basis_update.sv
design/fcbu_checker.sv
bench/fly_camera_basis_update_test.sv
